// File: sv/websocket_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and helpers of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned CFG_W       = 32;
   localparam int unsigned LEN_W       = 64;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned HCNT_W      = 4;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned RSP_DATA_W  = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSG   = 1'd1;

   // Result kinds carried in tuser.
   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
   localparam logic [1:0] KIND_DISCARDED = 2'd2;
   localparam logic [1:0] KIND_IGNORED   = 2'd3;

   localparam logic [3:0] OPC_CLOSE   = 4'h8;
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [3:0] HDR_BASE    = 4'd2;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [3:0] {
      MODE_HEADER  = 4'b0001,
      MODE_DATA    = 4'b0010,
      MODE_SKIP    = 4'b0100,
      MODE_CLOSING = 4'b1000
   } mode_type;

   // Result beat as held in the output register.
   typedef struct packed {
      logic [1:0]            kind;
      logic                  last;
      logic [RSP_DATA_W-1:0] data;
   } rsp_type;

   // Number of extended length bytes that follow the length code.
   function automatic logic [3:0] ext_bytes(input logic [6:0] code);
      logic [3:0] n;
      n = 4'd0;
      if (code == LEN_CODE_16) begin
         n = 4'd2;
      end else if (code == LEN_CODE_64) begin
         n = 4'd8;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: sv/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses received WebSocket frames one byte per beat and passes payload on
// unmasked, discarding frames and messages that exceed the set limits.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         tdata[7:0] data_byte
//  rsp_     out        tuser kind, tlast frame_done, tdata result fields
//  csr_     in         index 0 max_frame_size, index 1 max_message_size
//
//  One byte is accepted per clock cycle while the result beat moves on; each byte
//  passes the input register, then parse logic into the result register.
//  The per-byte path is 64-bit adds and compares against the limits.
//  Reset is synchronous and clears the parser state and both limits to zero.
//  When rsp_tready is low the result beat holds; one more byte is taken into
//  the input register and then req_tready drops until the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [DATA_W-1:0]           req_tdata,   // [7:0] data_byte

   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // [7:0] payload_byte, [11:8] opcode, [12] fin, [15:13] rsv_bits,
   // [16] frame_accepted, [17] closing, [23:18] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                  rsp_tuser,   // [1:0] kind
   output logic                        rsp_tlast,

   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [CSR_IDX_W-1:0]        csr_index,
   input  wire  [CFG_W-1:0]            csr_data
);

   // Configuration
   logic [CFG_W-1:0]  max_frame_ff;
   logic [CFG_W-1:0]  max_msg_ff;

   // Input register
   logic              in_valid_ff;
   logic [DATA_W-1:0] in_byte_ff;
   logic              adv;

   // Parser state
   mode_type          mode_ff,      mode_in;
   logic [HCNT_W-1:0] hdr_cnt_ff,   hdr_cnt_in;
   logic              fin_ff,       fin_in;
   logic [2:0]        rsv_ff,       rsv_in;
   logic [3:0]        opc_ff,       opc_in;
   logic              masked_ff,    masked_in;
   logic [6:0]        len_code_ff,  len_code_in;
   logic [LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic [KEY_W-1:0]  key_ff,       key_in;
   logic [LEN_W-1:0]  pay_cnt_ff,   pay_cnt_in;
   logic              skip_msg_ff,  skip_msg_in;
   logic              in_cont_ff,   in_cont_in;
   logic [LEN_W-1:0]  total_ff,     total_in;

   // Result register
   logic              rsp_valid_ff;
   rsp_type           rsp_ff,       rsp_in;

   // Parse intermediates
   logic [1:0]        kind;
   logic [DATA_W-1:0] pbyte;
   logic              done;
   logic              acc;
   logic              finish;
   logic [3:0]        hdr_size;
   logic [3:0]        ext_end;
   logic              hdr_last;
   logic              len_over;
   logic [LEN_W:0]    msg_sum;
   logic              msg_over;
   logic [LEN_W:0]    tot_sum;
   logic [LEN_W-1:0]  tot_sat;
   logic [LEN_W-1:0]  cnt_nxt;
   logic [DATA_W-1:0] key_byte;

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= '0;
         max_msg_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_FRAME: max_frame_ff <= csr_data;
            CSR_MAX_MSG:   max_msg_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // ------------------------------------------------------------------------
   // Limit checks
   // ------------------------------------------------------------------------
   assign len_over = frame_len_in > {{(LEN_W-CFG_W){1'b0}}, max_frame_ff};
   assign msg_sum  = {1'b0, frame_len_in} + {1'b0, total_ff};
   assign msg_over = msg_sum[LEN_W] ||
                     (msg_sum[LEN_W-1:0] > {{(LEN_W-CFG_W){1'b0}}, max_msg_ff});
   // Running message total saturates instead of wrapping.
   assign tot_sum  = {1'b0, total_ff} + {1'b0, frame_len_ff};
   assign tot_sat  = tot_sum[LEN_W] ? {LEN_W{1'b1}} : tot_sum[LEN_W-1:0];
   assign cnt_nxt  = pay_cnt_ff + {{(LEN_W-1){1'b0}}, 1'b1};
   assign ext_end  = HDR_BASE + ext_bytes(len_code_ff);
   assign hdr_size = HDR_BASE + ext_bytes(len_code_in) + (masked_in ? KEY_BYTES : 4'd0);
   assign hdr_last = ({1'b0, hdr_cnt_ff} + 5'd1) >= {1'b0, hdr_size};

   always_comb begin
      case (pay_cnt_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // ------------------------------------------------------------------------
   // Parse one byte
   // ------------------------------------------------------------------------
   always_comb begin
      mode_in      = mode_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      fin_in       = fin_ff;
      rsv_in       = rsv_ff;
      opc_in       = opc_ff;
      masked_in    = masked_ff;
      len_code_in  = len_code_ff;
      frame_len_in = frame_len_ff;
      key_in       = key_ff;
      pay_cnt_in   = pay_cnt_ff;
      skip_msg_in  = skip_msg_ff;
      in_cont_in   = in_cont_ff;
      total_in     = total_ff;
      kind         = KIND_HEADER;
      pbyte        = '0;
      done         = 1'b0;
      acc          = 1'b0;
      finish       = 1'b0;

      unique case (mode_ff) inside
         MODE_CLOSING: begin
            kind = KIND_IGNORED;
         end
         MODE_HEADER: begin
            kind = KIND_HEADER;
            if (hdr_cnt_ff == '0) begin
               fin_in       = in_byte_ff[7];
               rsv_in       = in_byte_ff[6:4];
               opc_in       = in_byte_ff[3:0];
               frame_len_in = '0;
               key_in       = '0;
               hdr_cnt_in   = 4'd1;
            end else begin
               if (hdr_cnt_ff == 4'd1) begin
                  masked_in    = in_byte_ff[7];
                  len_code_in  = in_byte_ff[6:0];
                  frame_len_in = (in_byte_ff[6:0] < LEN_CODE_16) ?
                                 {{(LEN_W-7){1'b0}}, in_byte_ff[6:0]} : '0;
               end else if (hdr_cnt_ff < ext_end) begin
                  frame_len_in = {frame_len_ff[LEN_W-DATA_W-1:0], in_byte_ff};
               end else begin
                  key_in = {key_ff[KEY_W-DATA_W-1:0], in_byte_ff};
               end

               if (hdr_last) begin
                  // Header complete: pick delivery or discard for the payload.
                  mode_in    = MODE_DATA;
                  pay_cnt_in = '0;
                  hdr_cnt_in = '0;
                  if (len_over) begin
                     mode_in = MODE_SKIP;
                     if (!fin_ff) skip_msg_in = 1'b1;
                  end else if (skip_msg_ff) begin
                     mode_in = MODE_SKIP;
                  end else if (in_cont_ff && msg_over) begin
                     mode_in = MODE_SKIP;
                     if (!fin_ff) skip_msg_in = 1'b1;
                  end
                  // A zero-length frame ends on its last header byte.
                  if (frame_len_in == '0) begin
                     finish = 1'b1;
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 4'd1;
               end
            end
         end
         MODE_DATA, MODE_SKIP: begin
            if (mode_ff == MODE_DATA) begin
               kind  = KIND_PAYLOAD;
               pbyte = masked_ff ? (in_byte_ff ^ key_byte) : in_byte_ff;
            end else begin
               kind = KIND_DISCARDED;
            end
            pay_cnt_in = cnt_nxt;
            if (cnt_nxt >= frame_len_ff) begin
               finish = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_HEADER;
         end
      endcase

      if (finish) begin
         done       = 1'b1;
         acc        = (mode_in != MODE_SKIP);
         mode_in    = (opc_in == OPC_CLOSE) ? MODE_CLOSING : MODE_HEADER;
         pay_cnt_in = '0;
         hdr_cnt_in = '0;
         if (fin_in) begin
            skip_msg_in = 1'b0;
            in_cont_in  = 1'b0;
            total_in    = '0;
         end else begin
            in_cont_in = 1'b1;
            // Zero-length frames add nothing to the message total.
            total_in   = (mode_ff == MODE_HEADER) ? total_ff : tot_sat;
         end
      end

      rsp_in.kind = kind;
      rsp_in.last = done;
      rsp_in.data = {6'd0, (mode_in == MODE_CLOSING), acc, rsv_in, fin_in, opc_in, pbyte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         hdr_cnt_ff  <= '0;
         fin_ff      <= 1'b0;
         rsv_ff      <= '0;
         opc_ff      <= '0;
         masked_ff   <= 1'b0;
         len_code_ff <= '0;
         frame_len_ff <= '0;
         key_ff      <= '0;
         pay_cnt_ff  <= '0;
         skip_msg_ff <= 1'b0;
         in_cont_ff  <= 1'b0;
         total_ff    <= '0;
      end else if (adv) begin
         mode_ff     <= mode_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         fin_ff      <= fin_in;
         rsv_ff      <= rsv_in;
         opc_ff      <= opc_in;
         masked_ff   <= masked_in;
         len_code_ff <= len_code_in;
         frame_len_ff <= frame_len_in;
         key_ff      <= key_in;
         pay_cnt_ff  <= pay_cnt_in;
         skip_msg_ff <= skip_msg_in;
         in_cont_ff  <= in_cont_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

   `WSD_ASSERT_NXT(a_closing_sticky, clock, reset, mode_ff == MODE_CLOSING, mode_ff == MODE_CLOSING, "closing state was left")
   `WSD_ASSERT_IMP(a_hdr_cnt_idle, clock, reset, mode_ff != MODE_HEADER, hdr_cnt_ff == '0, "header count not cleared outside header")
   `WSD_ASSERT_IMP(a_accept_done, clock, reset, rsp_valid_ff && rsp_ff.data[16], rsp_ff.last, "frame accepted without frame done")
   `WSD_ASSERT_NXT(a_adv_loads, clock, reset, adv, rsp_valid_ff, "parsed byte did not reach the result register")

endmodule

`default_nettype wire
